@@ rtl/core/bpm_pkg.sv @@
// Shared types, constants and the mode weight table for the probability merge core.
`default_nettype none
package bpm_pkg;

  // Count and datapath widths
  localparam int COUNT_BITS = 24;
  localparam int PROB_W     = 8;
  localparam int TOTAL_W    = COUNT_BITS + 1;
  // count_zero*256 + total/2 fits in COUNT_BITS+9 bits
  localparam int NUM_W      = COUNT_BITS + 9;
  // estimate quotient is at most 256
  localparam int EST_QW     = 9;
  // coefficient factor quotient is at most 255
  localparam int FAC_QW     = 8;
  localparam int FAC_NUM_W  = 2 * PROB_W;

  // Front queue between classifier and datapath
  localparam int FQ_DEPTH   = 4;
  localparam int FQ_PTR_W   = $clog2(FQ_DEPTH);
  localparam int FQ_CNT_W   = FQ_PTR_W + 1;

  // Result queue; must cover the datapath latency for full rate
  localparam int OQ_DEPTH   = 16;
  localparam int OQ_PTR_W   = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W   = OQ_PTR_W + 1;

  // Mode table
  localparam int MODE_TABLE_LAST = 20;
  localparam int MODE_IDX_W      = 5;

  // Configuration register indexes and reset values
  localparam logic REG_COEF_COUNT_SAT     = 1'b0;
  localparam logic REG_COEF_UPDATE_FACTOR = 1'b1;
  localparam logic [PROB_W-1:0] COEF_COUNT_SAT_RST     = 8'd24;
  localparam logic [PROB_W-1:0] COEF_UPDATE_FACTOR_RST = 8'd112;

  // Classified item held in the front queue
  typedef struct packed {
    logic                  cmd;
    logic [PROB_W-1:0]     prior;
    logic [COUNT_BITS-1:0] count_zero;
    logic [TOTAL_W-1:0]    total;
    // mode weight, or min(total, saturation) in coefficient mode
    logic [PROB_W-1:0]     wsel;
  } item_t;

  // One stage of the divider pipeline
  typedef struct packed {
    logic                 cmd;
    logic [PROB_W-1:0]    prior;
    logic [PROB_W-1:0]    weight;
    logic [TOTAL_W-1:0]   est_div;
    logic [NUM_W-1:0]     est_rem;
    logic [EST_QW-1:0]    est_q;
    logic [FAC_NUM_W-1:0] fac_rem;
    logic [FAC_QW-1:0]    fac_q;
  } div_stage_t;

  // Back end occupancy
  typedef struct packed {
    logic [OQ_CNT_W-1:0] reserved;
    logic [OQ_CNT_W-1:0] held;
  } back_status_t;

  // Mode/mv update weight by min(total, 20)
  function automatic logic [PROB_W-1:0] mode_weight(input logic [MODE_IDX_W-1:0] idx);
    logic [PROB_W-1:0] w;
    case (idx)
      5'd0:    w = 8'd0;
      5'd1:    w = 8'd6;
      5'd2:    w = 8'd12;
      5'd3:    w = 8'd19;
      5'd4:    w = 8'd25;
      5'd5:    w = 8'd32;
      5'd6:    w = 8'd38;
      5'd7:    w = 8'd44;
      5'd8:    w = 8'd51;
      5'd9:    w = 8'd57;
      5'd10:   w = 8'd64;
      5'd11:   w = 8'd70;
      5'd12:   w = 8'd76;
      5'd13:   w = 8'd83;
      5'd14:   w = 8'd89;
      5'd15:   w = 8'd96;
      5'd16:   w = 8'd102;
      5'd17:   w = 8'd108;
      5'd18:   w = 8'd115;
      5'd19:   w = 8'd121;
      5'd20:   w = 8'd128;
      default: w = 8'd128;
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/bpm_front.sv @@
// Front end: takes items, sums and classifies the counts, and queues them for the datapath.
`default_nettype none
module bpm_front (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            push,
  output logic                                 full,
  input  wire logic                            cmd,
  input  wire logic [bpm_pkg::PROB_W-1:0]      prior_prob,
  input  wire logic [bpm_pkg::COUNT_BITS-1:0]  count_zero,
  input  wire logic [bpm_pkg::COUNT_BITS-1:0]  count_one,
  input  wire logic [bpm_pkg::PROB_W-1:0]      sat_eff,
  input  wire logic                            q_pop,
  output logic                                 q_valid,
  output bpm_pkg::item_t                       q_item
);
  import bpm_pkg::*;

  logic [TOTAL_W-1:0]    total;
  logic [MODE_IDX_W-1:0] mode_idx;
  logic [PROB_W-1:0]     coef_cnt;
  item_t                 item_in;
  logic                  push_ok;

  item_t                 fq [FQ_DEPTH];
  logic [FQ_PTR_W-1:0]   wr_ptr;
  logic [FQ_PTR_W-1:0]   rd_ptr;
  logic [FQ_CNT_W-1:0]   count;

  // Classify: total, table index and capped coefficient count
  always_comb begin
    total    = {1'b0, count_zero} + {1'b0, count_one};
    mode_idx = (total > TOTAL_W'(MODE_TABLE_LAST)) ? MODE_IDX_W'(MODE_TABLE_LAST)
                                                  : total[MODE_IDX_W-1:0];
    coef_cnt = (total > {{(TOTAL_W-PROB_W){1'b0}}, sat_eff}) ? sat_eff
                                                             : total[PROB_W-1:0];
    item_in.cmd        = cmd;
    item_in.prior      = prior_prob;
    item_in.count_zero = count_zero;
    item_in.total      = total;
    item_in.wsel       = cmd ? coef_cnt : mode_weight(mode_idx);
  end

  assign full    = (count == FQ_CNT_W'(FQ_DEPTH));
  assign q_valid = (count != '0);
  assign push_ok = push && !full;
  assign q_item  = fq[rd_ptr];

  // Queue storage
  always_ff @(posedge clk) begin
    if (push_ok) begin
      fq[wr_ptr] <= item_in;
    end
  end

  // Queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push_ok, q_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/bpm_back.sv @@
// Back end: pipelined dividers for estimate and factor, blend, and the result queue.
`default_nettype none
module bpm_back (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        q_valid,
  input  wire bpm_pkg::item_t              q_item,
  output logic                             q_pop,
  input  wire logic [bpm_pkg::PROB_W-1:0]  factor_max,
  input  wire logic [bpm_pkg::PROB_W-1:0]  sat_eff,
  output logic                             empty,
  input  wire logic                        pop,
  output logic [bpm_pkg::PROB_W-1:0]       merged_prob,
  output bpm_pkg::back_status_t            status
);
  import bpm_pkg::*;

  logic              issue;
  logic              out_pop;
  logic [EST_QW:0]   dv;
  div_stage_t        ds [EST_QW+1];

  logic [PROB_W-1:0] est_clip;
  logic [PROB_W-1:0] f_sel;
  logic [PROB_W:0]   inv_f;
  logic              pv;
  logic [16:0]       pa;
  logic [15:0]       pb;
  logic [16:0]       acc;

  logic [PROB_W-1:0]   oq [OQ_DEPTH];
  logic [OQ_PTR_W-1:0] wr_ptr;
  logic [OQ_PTR_W-1:0] rd_ptr;
  logic [OQ_CNT_W-1:0] held;
  logic [OQ_CNT_W-1:0] reserved;

  // Take an item only when its result has a guaranteed slot
  assign issue   = q_valid && (reserved < OQ_CNT_W'(OQ_DEPTH));
  assign q_pop   = issue;
  assign out_pop = pop && !empty;

  // Stage 0: dividend setup and factor numerator
  always_ff @(posedge clk) begin
    if (issue) begin
      ds[0].cmd     <= q_item.cmd;
      ds[0].prior   <= q_item.prior;
      ds[0].weight  <= q_item.wsel;
      ds[0].est_div <= q_item.total;
      ds[0].est_rem <= {1'b0, q_item.count_zero, 8'b0}
                     + {{(NUM_W-TOTAL_W+1){1'b0}}, q_item.total[TOTAL_W-1:1]};
      ds[0].est_q   <= '0;
      ds[0].fac_rem <= FAC_NUM_W'(factor_max) * FAC_NUM_W'(q_item.wsel);
      ds[0].fac_q   <= '0;
    end
  end

  // Restoring division, one estimate quotient bit per stage; the factor divider takes one bit per stage up to FAC_QW
  for (genvar k = 1; k <= EST_QW; k++) begin : g_div
    localparam int ESH = EST_QW - k;
    logic [NUM_W:0]          est_d;
    logic [FAC_NUM_W-1:0]    fac_rem_next;
    logic [FAC_QW-1:0]       fac_q_next;
    div_stage_t              st;

    assign est_d = {{(NUM_W+1-TOTAL_W){1'b0}}, ds[k-1].est_div} << ESH;

    if (k <= FAC_QW) begin : g_fac
      localparam int FSH = FAC_QW - k;
      logic [FAC_NUM_W:0] fac_d;
      assign fac_d = {{(FAC_NUM_W+1-PROB_W){1'b0}}, sat_eff} << FSH;
      always_comb begin
        fac_rem_next = ds[k-1].fac_rem;
        fac_q_next   = ds[k-1].fac_q;
        if ({1'b0, ds[k-1].fac_rem} >= fac_d) begin
          fac_rem_next    = ds[k-1].fac_rem - fac_d[FAC_NUM_W-1:0];
          fac_q_next[FSH] = 1'b1;
        end
      end
    end else begin : g_fac_pass
      assign fac_rem_next = ds[k-1].fac_rem;
      assign fac_q_next   = ds[k-1].fac_q;
    end

    always_comb begin
      st         = ds[k-1];
      st.fac_rem = fac_rem_next;
      st.fac_q   = fac_q_next;
      if ({1'b0, ds[k-1].est_rem} >= est_d) begin
        st.est_rem      = ds[k-1].est_rem - est_d[NUM_W-1:0];
        st.est_q[ESH]   = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      ds[k] <= st;
    end
  end

  // Stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      dv <= '0;
      pv <= 1'b0;
    end else begin
      dv <= {dv[EST_QW-1:0], issue};
      pv <= dv[EST_QW];
    end
  end

  // Clip the estimate to 1..255 and pick the weight
  always_comb begin
    if (ds[EST_QW].est_q[EST_QW-1]) begin
      est_clip = 8'd255;
    end else if (ds[EST_QW].est_q[PROB_W-1:0] == '0) begin
      est_clip = 8'd1;
    end else begin
      est_clip = ds[EST_QW].est_q[PROB_W-1:0];
    end
    f_sel = ds[EST_QW].cmd ? ds[EST_QW].fac_q : ds[EST_QW].weight;
    inv_f = 9'd256 - {1'b0, f_sel};
  end

  // Blend products
  always_ff @(posedge clk) begin
    pa <= 17'(ds[EST_QW].prior) * 17'(inv_f);
    pb <= 16'(est_clip) * 16'(f_sel);
  end

  assign acc = pa + {1'b0, pb} + 17'd128;

  // Result queue storage
  always_ff @(posedge clk) begin
    if (pv) begin
      oq[wr_ptr] <= acc[15:8];
    end
  end

  // Result queue pointers, fill and credit counts
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      held     <= '0;
      reserved <= '0;
    end else begin
      if (pv) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (out_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({pv, out_pop})
        2'b10:   held <= held + 1'b1;
        2'b01:   held <= held - 1'b1;
        default: held <= held;
      endcase
      case ({issue, out_pop})
        2'b10:   reserved <= reserved + 1'b1;
        2'b01:   reserved <= reserved - 1'b1;
        default: reserved <= reserved;
      endcase
    end
  end

  assign empty           = (held == '0);
  assign merged_prob     = oq[rd_ptr];
  assign status.reserved = reserved;
  assign status.held     = held;

endmodule
`default_nettype wire

@@ rtl/core/binary_prob_merge_core.sv @@
// Binary probability merge core: adapts one 8-bit zero-branch probability from a prior and
// two 24-bit branch counts, in mode/mv form (fixed 21-entry weight table) or coefficient
// form (weight = max weight * min(total, saturation) / saturation). Both sides are
// queues: push/full in, empty/pop out. One item is taken per cycle while the result queue has
// a free slot to reserve; an item leaves the 4-entry input queue into the setup register, passes
// the 9-stage restoring divider that forms the count estimate (one quotient bit per stage,
// the factor divider runs alongside), then the product register and the queue write. The
// 16-entry result queue reserves a slot for every item in flight, so the input keeps flowing
// while results wait to be popped, until every slot is reserved.
// Configuration writes are always ready and must only happen while the core is idle.
`default_nettype none
module binary_prob_merge_core (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            push,
  output logic                                 full,
  input  wire logic                            cmd,
  input  wire logic [bpm_pkg::PROB_W-1:0]      prior_prob,
  input  wire logic [bpm_pkg::COUNT_BITS-1:0]  count_zero,
  input  wire logic [bpm_pkg::COUNT_BITS-1:0]  count_one,
  output logic                                 empty,
  input  wire logic                            pop,
  output logic [bpm_pkg::PROB_W-1:0]           merged_prob,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic                            cfg_index,
  input  wire logic [bpm_pkg::PROB_W-1:0]      cfg_data
);
  import bpm_pkg::*;

  logic [PROB_W-1:0] coef_count_saturation;
  logic [PROB_W-1:0] coef_update_factor;
  logic [PROB_W-1:0] sat_eff;
  logic              q_valid;
  logic              q_pop;
  item_t             q_item;
  back_status_t      bk_status;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_count_saturation <= COEF_COUNT_SAT_RST;
      coef_update_factor    <= COEF_UPDATE_FACTOR_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_COEF_COUNT_SAT:     coef_count_saturation <= cfg_data;
        REG_COEF_UPDATE_FACTOR: coef_update_factor    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Zero saturation acts as one
  assign sat_eff = (coef_count_saturation == '0) ? 8'd1 : coef_count_saturation;

  bpm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .cmd        (cmd),
    .prior_prob (prior_prob),
    .count_zero (count_zero),
    .count_one  (count_one),
    .sat_eff    (sat_eff),
    .q_pop      (q_pop),
    .q_valid    (q_valid),
    .q_item     (q_item)
  );

  bpm_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop),
    .factor_max    (coef_update_factor),
    .sat_eff       (sat_eff),
    .empty         (empty),
    .pop           (pop),
    .merged_prob   (merged_prob),
    .status        (bk_status)
  );

`ifndef ASSERT_OFF
  // Back end never takes from an empty front queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("back end popped an empty front queue");

  // An accepted item is in the front queue on the next cycle
  a_push_lands: assert property (@(posedge clk) disable iff (rst)
    (push && !full) |=> q_valid)
    else $error("accepted item missing from front queue");

  // Results held never exceed the slots reserved for them
  a_held_le_reserved: assert property (@(posedge clk) disable iff (rst)
    bk_status.held <= bk_status.reserved)
    else $error("result queue holds more than reserved");

  // Credit never exceeds the result queue depth
  a_reserved_bound: assert property (@(posedge clk) disable iff (rst)
    bk_status.reserved <= OQ_CNT_W'(OQ_DEPTH))
    else $error("result queue credit overrun");
`endif

endmodule
`default_nettype wire
